FILE: hw/rtl/fmmn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmmn_pkg
// Types and constants shared by the min-max normalizer modules.
// ----------------------------------------------------------------------------
package fmmn_pkg;

	localparam int VAL_W  = 32;
	localparam int FIDX_W = 10;
	localparam int CFG_W  = 11;
	localparam int KIND_W = 3;
	localparam int FRAC_SH = 24;
	localparam int DEN_W  = VAL_W + 1;
	localparam int NUM_W  = VAL_W + 1 + FRAC_SH;

	localparam logic [KIND_W-1:0] KIND_OBSERVE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FINALIZE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NORM     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LOAD     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = 11'd1024;

	localparam logic [VAL_W-1:0] MIN_SENTINEL = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] MAX_SENTINEL = 32'h8000_0000;
	localparam logic [VAL_W-1:0] ONE_Q16      = 32'h0001_0000;

	typedef enum logic [2:0] {
		OP_OBSERVE,
		OP_FINALIZE,
		OP_NORM,
		OP_LOAD,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              in_range;
		logic [FIDX_W-1:0] idx;
		logic [VAL_W-1:0]  value;
		logic [VAL_W-1:0]  lmax;
	} cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/feature_min_max_normalizer.sv
`default_nettype none
// Back end per word: observe reads and writes back one table entry, load writes
// one, and clear and finalize walk the active features, one table entry per cycle.
// Normalize runs the 57-step one-bit-per-cycle divider when the range is nonzero.
// Output stall holds a finished result until the output register is free.
// A two-word queue registers input words and decouples input from the back end.
// After reset a sweep loads the sentinels into all MAX_FEATURES entries; input stalls.
// ----------------------------------------------------------------------------
// feature_min_max_normalizer
// Per-feature min/max tracking with finalize and Q8.24 normalization.
// ----------------------------------------------------------------------------
module feature_min_max_normalizer #(
	parameter int MAX_FEATURES = 1024
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [fmmn_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [fmmn_pkg::KIND_W-1:0]  kind,
	input  wire  [fmmn_pkg::FIDX_W-1:0]  feature_index,
	input  wire  [fmmn_pkg::VAL_W-1:0]   sample_value,
	input  wire  [fmmn_pkg::VAL_W-1:0]   load_maximum,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         result_kind,
	output logic [fmmn_pkg::VAL_W-1:0]   scaled_value,
	output logic [fmmn_pkg::CFG_W-1:0]   zero_feature_count,
	output logic                         range_is_zero,
	output logic                         saturated
);
	import fmmn_pkg::*;

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;
	logic init_busy;

	fmmn_front #(
		.MAX_FEATURES(MAX_FEATURES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.feature_index(feature_index),
		.sample_value (sample_value),
		.load_maximum (load_maximum),
		.init_busy    (init_busy),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_cmd        (q_cmd)
	);

	fmmn_back #(
		.MAX_FEATURES(MAX_FEATURES)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.q_valid           (q_valid),
		.q_pop             (q_pop),
		.q_cmd             (q_cmd),
		.init_busy         (init_busy),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.result_kind       (result_kind),
		.scaled_value      (scaled_value),
		.zero_feature_count(zero_feature_count),
		.range_is_zero     (range_is_zero),
		.saturated         (saturated)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/fmmn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmmn_front
// Accepts input words, decodes the kind and queues commands for the back end.
// ----------------------------------------------------------------------------
module fmmn_front #(
	parameter int MAX_FEATURES = 1024
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [fmmn_pkg::KIND_W-1:0]  kind,
	input  wire  [fmmn_pkg::FIDX_W-1:0]  feature_index,
	input  wire  [fmmn_pkg::VAL_W-1:0]   sample_value,
	input  wire  [fmmn_pkg::VAL_W-1:0]   load_maximum,
	input  wire                          init_busy,
	output logic                         q_valid,
	input  wire                          q_pop,
	output fmmn_pkg::cmd_t               q_cmd
);
	import fmmn_pkg::*;

	cmd_t        fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	cmd_t        dec;
	logic        keep;
	logic        accept;
	logic        push;
	logic        pop;

	always_comb begin
		dec.in_range = (32'(feature_index) < MAX_FEATURES);
		dec.idx      = feature_index;
		dec.value    = sample_value;
		dec.lmax     = load_maximum;
		dec.op       = OP_OBSERVE;
		keep         = 1'b0;
		case (kind)
			KIND_OBSERVE: begin
				dec.op = OP_OBSERVE;
				keep   = dec.in_range;
			end
			KIND_FINALIZE: begin
				dec.op = OP_FINALIZE;
				keep   = 1'b1;
			end
			KIND_NORM: begin
				dec.op = OP_NORM;
				keep   = 1'b1;
			end
			KIND_LOAD: begin
				dec.op = OP_LOAD;
				keep   = dec.in_range;
			end
			KIND_CLEAR: begin
				dec.op = OP_CLEAR;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = (count_q == 2'd2) || init_busy;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && keep;
	assign pop      = q_pop && (count_q != 2'd0);
	assign q_valid  = (count_q != 2'd0);
	assign q_cmd    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/fmmn_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmmn_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmmn_div #(
	parameter int NW = 57,
	parameter int DW = 33
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	input  wire  [NW-1:0] num,
	input  wire  [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CNT_W = $clog2(NW + 1);

	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [NW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      sh;
	logic [DW+1:0]    diff;
	logic             borrow;

	assign sh     = {rem_q, quo_q[NW-1]};
	assign diff   = {1'b0, sh} - {2'b00, den_q};
	assign borrow = diff[DW+1];
	assign done   = done_q;
	assign quo    = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= borrow ? sh[DW-1:0] : diff[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ~borrow};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/fmmn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmmn_back
// Holds the min/max table and carries out queued commands.
// ----------------------------------------------------------------------------
module fmmn_back #(
	parameter int MAX_FEATURES = 1024
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [fmmn_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire                          q_valid,
	output logic                         q_pop,
	input  fmmn_pkg::cmd_t               q_cmd,
	output logic                         init_busy,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         result_kind,
	output logic [fmmn_pkg::VAL_W-1:0]   scaled_value,
	output logic [fmmn_pkg::CFG_W-1:0]   zero_feature_count,
	output logic                         range_is_zero,
	output logic                         saturated
);
	import fmmn_pkg::*;

	localparam int AW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CLW = $clog2(MAX_FEATURES + 1);
	localparam int CW  = (CLW > CFG_W) ? CLW : CFG_W;
	localparam int EW  = 2 * VAL_W;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_OBS,
		S_FIN,
		S_CLR,
		S_NRD,
		S_DIV,
		S_OUT
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [CFG_W-1:0] active_q;
	logic [CW-1:0]    cnt_q;
	logic [CFG_W-1:0] unseen_q;
	logic             neg_q;

	logic             res_kind_q;
	logic [VAL_W-1:0] res_value_q;
	logic [CFG_W-1:0] res_count_q;
	logic             res_zero_q;
	logic             res_sat_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic [VAL_W-1:0] out_value_q;
	logic [CFG_W-1:0] out_count_q;
	logic             out_zero_q;
	logic             out_sat_q;

	logic [EW-1:0]    mem [MAX_FEATURES];
	logic [EW-1:0]    rd_q;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [EW-1:0]    wdata;
	logic             re;
	logic [AW-1:0]    raddr;

	logic [CW-1:0]    wl;
	logic [CW:0]      cnt_nx;
	logic [AW-1:0]    cmd_addr;
	logic [AW-1:0]    q_addr;
	logic [VAL_W-1:0] mn;
	logic [VAL_W-1:0] mx;
	logic [VAL_W-1:0] obs_mn;
	logic [VAL_W-1:0] obs_mx;
	logic [VAL_W-1:0] fin_mn1;
	logic             fin_unseen;
	logic [EW-1:0]    fin_w;
	logic [DEN_W-1:0] den;
	logic [DEN_W-1:0] dn;
	logic [NUM_W-1:0] num;
	logic [NUM_W-1:0] num_mag;
	logic [DEN_W-1:0] den_mag;
	logic             div_start;
	logic             div_done;
	logic [NUM_W-1:0] quo;
	logic             out_free;
	logic             q_over;
	logic             q_under;
	logic [VAL_W-1:0] q_neg;

	assign wl       = (CW'(active_q) > CW'(MAX_FEATURES)) ? CW'(MAX_FEATURES) : CW'(active_q);
	assign cnt_nx   = {1'b0, cnt_q} + 1'b1;
	assign cmd_addr = AW'(cmd_q.idx);
	assign q_addr   = AW'(q_cmd.idx);
	assign mn       = rd_q[VAL_W-1:0];
	assign mx       = rd_q[EW-1:VAL_W];

	assign obs_mn = ($signed(cmd_q.value) < $signed(mn)) ? cmd_q.value : mn;
	assign obs_mx = ($signed(cmd_q.value) > $signed(mx)) ? cmd_q.value : mx;

	assign fin_mn1    = (mn == mx) ? '0 : mn;
	assign fin_unseen = $signed(mx) < $signed(fin_mn1);
	assign fin_w      = fin_unseen ? {ONE_Q16, {VAL_W{1'b0}}} : {mx, fin_mn1};

	assign den     = {mx[VAL_W-1], mx} - {mn[VAL_W-1], mn};
	assign dn      = {cmd_q.value[VAL_W-1], cmd_q.value} - {mn[VAL_W-1], mn};
	assign num     = {dn, {FRAC_SH{1'b0}}};
	assign num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
	assign den_mag = den[DEN_W-1] ? (~den + 1'b1) : den;

	assign q_over  = (quo > NUM_W'(32'h7FFF_FFFF));
	assign q_under = (quo > NUM_W'(33'h0_8000_0000));
	assign q_neg   = ~quo[VAL_W-1:0] + 1'b1;

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign div_start = (state_q == S_NRD) && (den != '0);
	assign init_busy = (state_q == S_INIT);

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = {MAX_SENTINEL, MIN_SENTINEL};
		re    = 1'b0;
		raddr = q_addr;
		case (state_q)
			S_INIT, S_CLR: begin
				we = 1'b1;
			end
			S_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						OP_OBSERVE, OP_NORM: begin
							re = q_cmd.in_range;
						end
						OP_FINALIZE: begin
							re    = 1'b1;
							raddr = '0;
						end
						OP_LOAD: begin
							we    = 1'b1;
							waddr = q_addr;
							wdata = {q_cmd.lmax, q_cmd.value};
						end
						default: begin
							re = 1'b0;
						end
					endcase
				end
			end
			S_OBS: begin
				we    = 1'b1;
				waddr = cmd_addr;
				wdata = {obs_mx, obs_mn};
			end
			S_FIN: begin
				we    = 1'b1;
				wdata = fin_w;
				raddr = cnt_nx[AW-1:0];
				re    = (cnt_nx < {1'b0, wl});
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	fmmn_div #(
		.NW(NUM_W),
		.DW(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_mag),
		.den   (den_mag),
		.done  (div_done),
		.quo   (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cmd_q       <= '0;
			active_q    <= ACTIVE_RESET;
			cnt_q       <= '0;
			unseen_q    <= '0;
			neg_q       <= 1'b0;
			res_kind_q  <= 1'b0;
			res_value_q <= '0;
			res_count_q <= '0;
			res_zero_q  <= 1'b0;
			res_sat_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q  <= 1'b0;
			out_value_q <= '0;
			out_count_q <= '0;
			out_zero_q  <= 1'b0;
			out_sat_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (cnt_q == CW'(MAX_FEATURES - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_nx[CW-1:0];
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						cmd_q <= q_cmd;
						cnt_q <= '0;
						case (q_cmd.op)
							OP_OBSERVE: begin
								state_q <= S_OBS;
							end
							OP_NORM: begin
								if (q_cmd.in_range) begin
									state_q <= S_NRD;
								end else begin
									res_kind_q  <= 1'b0;
									res_value_q <= '0;
									res_count_q <= '0;
									res_zero_q  <= 1'b1;
									res_sat_q   <= 1'b0;
									state_q     <= S_OUT;
								end
							end
							OP_FINALIZE: begin
								unseen_q <= '0;
								if (wl == '0) begin
									res_kind_q  <= 1'b1;
									res_value_q <= '0;
									res_count_q <= '0;
									res_zero_q  <= 1'b0;
									res_sat_q   <= 1'b0;
									state_q     <= S_OUT;
								end else begin
									state_q <= S_FIN;
								end
							end
							OP_CLEAR: begin
								if (wl != '0) begin
									state_q <= S_CLR;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_OBS: begin
					state_q <= S_IDLE;
				end
				S_FIN: begin
					unseen_q <= unseen_q + CFG_W'(fin_unseen);
					if (cnt_nx == {1'b0, wl}) begin
						res_kind_q  <= 1'b1;
						res_value_q <= '0;
						res_count_q <= unseen_q + CFG_W'(fin_unseen);
						res_zero_q  <= 1'b0;
						res_sat_q   <= 1'b0;
						state_q     <= S_OUT;
					end else begin
						cnt_q <= cnt_nx[CW-1:0];
					end
				end
				S_CLR: begin
					if (cnt_nx == {1'b0, wl}) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_nx[CW-1:0];
					end
				end
				S_NRD: begin
					res_kind_q  <= 1'b0;
					res_count_q <= '0;
					neg_q       <= num[NUM_W-1] ^ den[DEN_W-1];
					if (den == '0) begin
						res_value_q <= '0;
						res_zero_q  <= 1'b1;
						res_sat_q   <= 1'b0;
						state_q     <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						res_zero_q <= 1'b0;
						if (neg_q) begin
							res_sat_q   <= q_under;
							res_value_q <= q_under ? MAX_SENTINEL : q_neg;
						end else begin
							res_sat_q   <= q_over;
							res_value_q <= q_over ? MIN_SENTINEL : quo[VAL_W-1:0];
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= res_kind_q;
						out_value_q <= res_value_q;
						out_count_q <= res_count_q;
						out_zero_q  <= res_zero_q;
						out_sat_q   <= res_sat_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign result_kind        = out_kind_q;
	assign scaled_value       = out_value_q;
	assign zero_feature_count = out_count_q;
	assign range_is_zero      = out_zero_q;
	assign saturated          = out_sat_q;

endmodule
`default_nettype wire

FILE: tb/feature_min_max_normalizer_test.sv
// ----------------------------------------------------------------------------
// feature_min_max_normalizer_test
// Drives observe, finalize, normalize, load and clear words into the
// normalizer under several active_features settings, with random idling on
// both sides and one long output hold-off. A local copy of the min/max table
// predicts every result, and each result is compared field by field.
// ----------------------------------------------------------------------------
module feature_min_max_normalizer_test;
	import fmmn_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE5 = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
	localparam int TABLE_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 4000;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [FIDX_W-1:0]  idx;
		logic [VAL_W-1:0]   val;
		logic [VAL_W-1:0]   lmax;
		int                 gap;
	} word_t;

	typedef struct {
		logic               rkind;
		logic [VAL_W-1:0]   scaled;
		logic [CFG_W-1:0]   zcount;
		logic               rzero;
		logic               sat;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [FIDX_W-1:0] feature_index = '0;
	logic [VAL_W-1:0] sample_value = '0;
	logic [VAL_W-1:0] load_maximum = '0;
	logic out_valid;
	logic out_stall = 0;
	logic result_kind;
	logic [VAL_W-1:0] scaled_value;
	logic [CFG_W-1:0] zero_feature_count;
	logic range_is_zero;
	logic saturated;

	word_t   pending_words[$];
	result_t expected_results[$];
	longint  min_tab[TABLE_DEPTH];
	longint  max_tab[TABLE_DEPTH];
	int      active_count = 1024;
	int      errors = 0;
	int      cycles = 0;
	int      send_wait = 0;
	int      rx_wait = 0;
	bit      send_idle = 0;
	bit      rx_idle = 0;
	logic    hold_request = 0;
	logic    hold_started = 0;
	int      hold_left = 0;

	feature_min_max_normalizer u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.feature_index(feature_index), .sample_value(sample_value),
		.load_maximum(load_maximum), .out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .scaled_value(scaled_value),
		.zero_feature_count(zero_feature_count), .range_is_zero(range_is_zero),
		.saturated(saturated)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	task automatic report(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic apply_word(input word_t w);
		longint v, num, den, q;
		int n, cnt;
		result_t r;
		v = longint'($signed(w.val));
		n = active_count > TABLE_DEPTH ? TABLE_DEPTH : active_count;
		r = '{1'b0, '0, '0, 1'b0, 1'b0};
		case (w.kind)
			KIND_OBSERVE: begin
				if (v < min_tab[w.idx]) min_tab[w.idx] = v;
				if (v > max_tab[w.idx]) max_tab[w.idx] = v;
			end
			KIND_FINALIZE: begin
				cnt = 0;
				for (int i = 0; i < n; i++) begin
					if (min_tab[i] == max_tab[i]) min_tab[i] = 0;
					if (max_tab[i] < min_tab[i]) begin
						cnt++;
						max_tab[i] = 65536;
						min_tab[i] = 0;
					end
				end
				r.rkind = 1'b1;
				r.zcount = cnt[CFG_W-1:0];
				expected_results.insert(expected_results.size(), r);
			end
			KIND_NORM: begin
				den = max_tab[w.idx] - min_tab[w.idx];
				r.rzero = 1'b1;
				if (den != 0) begin
					num = (v - min_tab[w.idx]) * 64'sd16777216;
					q = num / den;
					r.rzero = 1'b0;
					if (q > 64'sd2147483647) begin
						q = 64'sd2147483647;
						r.sat = 1'b1;
					end else if (q < -64'sd2147483648) begin
						q = -64'sd2147483648;
						r.sat = 1'b1;
					end
					r.scaled = q[VAL_W-1:0];
				end
				expected_results.insert(expected_results.size(), r);
			end
			KIND_LOAD: begin
				min_tab[w.idx] = v;
				max_tab[w.idx] = longint'($signed(w.lmax));
			end
			KIND_CLEAR: begin
				for (int i = 0; i < n; i++) begin
					min_tab[i] = 64'sd2147483647;
					max_tab[i] = -64'sd2147483648;
				end
			end
			default: ;
		endcase
	endtask

	task automatic add(input logic [KIND_W-1:0] k, input int idx,
			input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] lm);
		word_t w;
		w.kind = k;
		w.idx = idx[FIDX_W-1:0];
		w.val = v;
		w.lmax = lm;
		w.gap = send_idle ? $urandom_range(0, 17) : 0;
		pending_words.insert(pending_words.size(), w);
	endtask

	function automatic logic [VAL_W-1:0] draw_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) return VAL_W'($signed($urandom_range(0, 524288)) - 262144);
		if (sel < 8) return $urandom();
		case ($urandom_range(0, 3))
			0: return MIN_SENTINEL;
			1: return MAX_SENTINEL;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic int draw_index();
		int lim;
		lim = active_count < 1 ? 1 : (active_count > 24 ? 24 : active_count);
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, lim - 1);
		return $urandom_range(0, TABLE_DEPTH - 1);
	endfunction

	task automatic add_random(input int count);
		int sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 42) add(KIND_OBSERVE, draw_index(), draw_value(), '0);
			else if (sel < 76) add(KIND_NORM, draw_index(), draw_value(), '0);
			else if (sel < 88) add(KIND_LOAD, draw_index(), draw_value(), draw_value());
			else if (sel < 94) add(KIND_FINALIZE, $urandom(), $urandom(), $urandom());
			else if (sel < 97) add(KIND_CLEAR, $urandom(), $urandom(), $urandom());
			else add(KIND_W'(KIND_SPARE5 + $urandom_range(0, 2)), $urandom(), $urandom(),
				$urandom());
		end
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_active(input int value);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		active_count = value;
	endtask

	always @(posedge clk) begin
		bit taken;
		word_t w;
		if (arst_n) begin
			taken = in_valid && !in_stall;
			if (taken) begin
				w.kind = kind;
				w.idx = feature_index;
				w.val = sample_value;
				w.lmax = load_maximum;
				apply_word(w);
			end
			if (!in_valid || taken) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					kind <= w.kind;
					feature_index <= w.idx;
					sample_value <= w.val;
					load_maximum <= w.lmax;
					send_wait = w.gap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report("result with nothing expected");
				end else begin
					e = expected_results.pop_front();
					if (result_kind !== e.rkind)
						report($sformatf("result_kind %0d, want %0d", result_kind, e.rkind));
					if (scaled_value !== e.scaled)
						report($sformatf("scaled_value %h, want %h", scaled_value, e.scaled));
					if (zero_feature_count !== e.zcount)
						report($sformatf("zero_feature_count %0d, want %0d",
							zero_feature_count, e.zcount));
					if (range_is_zero !== e.rzero)
						report($sformatf("range_is_zero %0d, want %0d", range_is_zero, e.rzero));
					if (saturated !== e.sat)
						report($sformatf("saturated %0d, want %0d", saturated, e.sat));
				end
				rx_wait = rx_idle ? $urandom_range(0, 17) : 0;
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_stall <= (hold_left != 0) || (rx_wait != 0);
		end
	end

	always @(posedge clk) begin
		if (hold_request && !hold_started) begin
			hold_started <= 1'b1;
			hold_left <= 3000;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			min_tab[i] = 64'sd2147483647;
			max_tab[i] = -64'sd2147483648;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		write_active(1024);
		send_idle = 1;
		rx_idle = 1;
		// edge cases: sentinels, never seen, constant, negative constant
		add(KIND_NORM, 3, 32'h0001_0000, '0);
		add(KIND_OBSERVE, 1, 32'hFFFF_0000, '0);
		add(KIND_OBSERVE, 2, 32'h0002_0000, '0);
		add(KIND_OBSERVE, 4, 32'h0000_8000, '0);
		add(KIND_OBSERVE, 4, 32'h0003_0000, '0);
		add(KIND_NORM, 4, 32'h0001_0000, '0);
		add(KIND_LOAD, 5, 32'h0000_0000, 32'h0000_0001);
		add(KIND_NORM, 5, MIN_SENTINEL, '0);
		add(KIND_NORM, 5, MAX_SENTINEL, '0);
		add(KIND_LOAD, 6, 32'h0001_0000, 32'hFFFF_0000);
		add(KIND_NORM, 6, 32'h0000_0000, '0);
		add(KIND_LOAD, 7, MAX_SENTINEL, MIN_SENTINEL);
		add(KIND_NORM, 7, MIN_SENTINEL, '0);
		add(KIND_NORM, 7, MAX_SENTINEL, '0);
		add(KIND_NORM, 1023, 32'hFFFF_FFFF, '0);
		add(KIND_SPARE5, 1023, '1, '1);
		add(KIND_SPARE6, 0, '0, '0);
		add(KIND_SPARE7, 512, 32'h5555_5555, 32'hAAAA_AAAA);
		add(KIND_FINALIZE, 0, '0, '0);
		add(KIND_NORM, 1, 32'h0000_8000, '0);
		add(KIND_NORM, 2, 32'h0002_0000, '0);
		add(KIND_NORM, 9, 32'h0000_8000, '0);
		add(KIND_CLEAR, '1, '1, '1);
		add(KIND_NORM, 4, 32'h0001_0000, '0);
		add(KIND_FINALIZE, 0, '0, '0);
		add_random(250);

		write_active(1);
		send_idle = 0;
		rx_idle = 0;
		add_random(250);

		write_active(24);
		hold_request <= 1'b1;
		for (int i = 0; i < 60; i++) add(KIND_NORM, draw_index(), draw_value(), '0);
		add_random(240);

		write_active(2047);
		send_idle = 1;
		rx_idle = 1;
		add_random(250);

		write_active(0);
		rx_idle = 0;
		add_random(200);

		write_active(7);
		send_idle = 0;
		rx_idle = 1;
		add_random(250);

		write_active(1024);
		send_idle = 1;
		add_random(250);

		wait_idle();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
